[rtl/core/mexp_pkg.sv]
// Package for the modular exponentiation unit: operand width, counter
// widths and the status struct shared by the multiplier lanes.
// No dependencies.
package mexp_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
   localparam int CSR_IDX_WIDTH = 1;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_EXPONENT = 1'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MODULUS  = 1'd1;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

[rtl/core/mexp_if.sv]
// Handshake interfaces for the request and response channels.
// Depends on mexp_pkg.
interface mexp_req_if
   import mexp_pkg::*;
   ();
   logic        valid;
   logic        ready;
   operand_type base_value;
   modport source (output valid, output base_value, input ready);
   modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_rsp_if
   import mexp_pkg::*;
   ();
   logic        valid;
   logic        ready;
   operand_type power_result;
   modport source (output valid, output power_result, input ready);
   modport sink   (input valid, input power_result, output ready);
endinterface

[rtl/core/mexp_cell.sv]
// One bit cell of the multiplier operand chain: loads a bit, or takes its
// neighbor's bit on a shift. Depends on nothing.
module mexp_cell (
   input  logic clock,
   input  logic load,
   input  logic shift,
   input  logic load_bit,
   input  logic prev_bit,
   output logic bit_out
);
   logic bit_ff;
   logic bit_in;

   always_comb begin
      bit_in = bit_ff;
      if (load) begin
         bit_in = load_bit;
      end else if (shift) begin
         bit_in = prev_bit;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;
endmodule

[rtl/core/mexp_mulmod.sv]
// Shift-add modular multiplier: a*b mod m, one multiplier bit per cycle,
// MSB first, taken from a chain of mexp_cell. Depends on mexp_pkg, mexp_cell.
module mexp_mulmod
   import mexp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  operand_type   op_a,
   input  operand_type   op_b,
   input  operand_type   modulus,
   output operand_type   product,
   output mm_status_type status
);
   logic [OPERAND_WIDTH-1:0] chain;
   operand_type              acc_ff, acc_in;
   logic [CNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [OPERAND_WIDTH:0]   dbl, dbl_red, sum;

   for (genvar i = 0; i < OPERAND_WIDTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         mexp_cell u_cell (
            .clock(clock), .load(start), .shift(busy_ff),
            .load_bit(op_b[i]), .prev_bit(1'b0), .bit_out(chain[i])
         );
      end else begin : g_rest
         mexp_cell u_cell (
            .clock(clock), .load(start), .shift(busy_ff),
            .load_bit(op_b[i]), .prev_bit(chain[i-1]), .bit_out(chain[i])
         );
      end
   end

   always_comb begin
      dbl     = {acc_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, modulus}) ? dbl - {1'b0, modulus} : dbl;
      sum     = dbl_red + (chain[OPERAND_WIDTH-1] ? {1'b0, op_a} : '0);
      if (sum >= {1'b0, modulus}) begin
         sum = sum - {1'b0, modulus};
      end
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[OPERAND_WIDTH-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product     = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;
endmodule

[rtl/core/modular_exponentiation_unit.sv]
// Top level of the modular exponentiation unit (right-to-left binary).
// Depends on mexp_pkg, mexp_if, mexp_mulmod, mexp_cell.
//
// Channel   Dir  Payload             Handshake
// req_ch    in   base_value   [31:0] valid/ready
// rsp_ch    out  power_result [31:0] valid/ready
// csr_*     in   index [0:0], data   csr_we, no wait
//
// An item first reduces the base mod m, then each exponent bit runs two shift-add
// multiplier lanes (result*base, base*base) side by side.
// The multiplier lanes set the rate. Modulus of one or zero returns 0 at once.
// Synchronous active-high reset clears control; registers reset to exp 0, mod 1.
// One item is computed at a time; the result register holds until rsp_ch.ready.
module modular_exponentiation_unit
   import mexp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   mexp_req_if.sink                 req_ch,
   mexp_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  operand_type              csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RED  = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0]           state_ff, state_in;
   operand_type          exp_cfg_ff, mod_cfg_ff;
   operand_type          base_ff, base_in;      // reduced base / squares
   operand_type          bsh_ff, bsh_in;        // base bits for reduction
   operand_type          res_ff, res_in;        // running result
   operand_type          esh_ff, esh_in;        // exponent, LSB first
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   operand_type          rsp_data_ff, rsp_data_in;
   logic                 start;
   operand_type          prod_res, prod_sq;
   mm_status_type        st_res, st_sq;
   logic [OPERAND_WIDTH:0] rem;
   logic                 accept;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign start        = (state_ff == S_MUL);

   // result lane and squaring lane
   mexp_mulmod u_mul_res (
      .clock(clock), .reset(reset), .start(start), .op_a(res_ff),
      .op_b(base_ff), .modulus(mod_cfg_ff), .product(prod_res), .status(st_res)
   );
   mexp_mulmod u_mul_sq (
      .clock(clock), .reset(reset), .start(start), .op_a(base_ff),
      .op_b(base_ff), .modulus(mod_cfg_ff), .product(prod_sq), .status(st_sq)
   );

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      bsh_in       = bsh_ff;
      res_in       = res_ff;
      esh_in       = esh_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      // base mod m, one base bit per cycle
      rem = {base_ff, bsh_ff[OPERAND_WIDTH-1]};
      if (rem >= {1'b0, mod_cfg_ff}) begin
         rem = rem - {1'b0, mod_cfg_ff};
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               bsh_in  = req_ch.base_value;
               base_in = '0;
               esh_in  = exp_cfg_ff;
               cnt_in  = '0;
               if (mod_cfg_ff <= operand_type'(1)) begin
                  res_in   = '0;
                  state_in = S_FIN;
               end else begin
                  res_in   = operand_type'(1);
                  state_in = S_RED;
               end
            end
         end
         S_RED: begin
            base_in = rem[OPERAND_WIDTH-1:0];
            bsh_in  = {bsh_ff[OPERAND_WIDTH-2:0], 1'b0};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (st_res.done) begin
               if (esh_ff[0]) begin
                  res_in = prod_res;
               end
               base_in = prod_sq;
               esh_in  = {1'b0, esh_ff[OPERAND_WIDTH-1:1]};
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == CNT_WIDTH'(OPERAND_WIDTH - 1)) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      bsh_ff      <= bsh_in;
      res_ff      <= res_in;
      esh_ff      <= esh_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         exp_cfg_ff   <= '0;
         mod_cfg_ff   <= operand_type'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_EXPONENT) begin
            exp_cfg_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_MODULUS) begin
            mod_cfg_ff <= csr_wdata;
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.power_result = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // both lanes run in lockstep
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (st_res.done == st_sq.done) && (st_res.busy == st_sq.busy))
      else $error("multiplier lanes out of step");
   // lanes idle while waiting for an item
   a_idle_lanes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !st_res.busy)
      else $error("lane busy while idle");
   // result is reduced
   a_result_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff < mod_cfg_ff || mod_cfg_ff == '0))
      else $error("result not below modulus");
   // an accepted item leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("item accepted but no work started");
`endif
endmodule

[test/modular_exponentiation_unit_test.sv]
`timescale 1ns / 100ps
// Testbench for modular_exponentiation_unit: drives base values, predicts
// base^exponent mod modulus in a scoreboard class. Depends on mexp_pkg, mexp_if, modular_exponentiation_unit.
module modular_exponentiation_unit_test;
   import mexp_pkg::*;

   // Holds expected powers; computes them with its own copy of the registers.
   class power_scoreboard;
      logic [31:0] exp_reg;
      logic [31:0] mod_reg;
      logic [31:0] pending_powers[$];
      int          errors;

      function new();
         exp_reg = 0;
         mod_reg = 1;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_WIDTH-1:0] idx, logic [31:0] val);
         if (idx == CSR_EXPONENT) exp_reg = val;
         else if (idx == CSR_MODULUS) mod_reg = val;
      endfunction

      // exact 64-bit product reduced; operands below 2^32 so no overflow
      function logic [31:0] power_of(logic [31:0] b);
         logic [63:0] acc, sq, m;
         if (mod_reg <= 1) return 0;
         m = mod_reg;
         sq = b % m;
         acc = 1;
         for (int i = 0; i < 32; i++) begin
            if (exp_reg[i]) acc = (acc * sq) % m;
            sq = (sq * sq) % m;
         end
         return acc[31:0];
      endfunction

      function void note_base(logic [31:0] b);
         pending_powers = {pending_powers, power_of(b)};
      endfunction

      function void check_power(logic [31:0] got);
         logic [31:0] want;
         if (pending_powers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending_powers.pop_front();
         if (want !== got) begin
            $display("%0t: power_result mismatch, expected %h, actual %h",
                     $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_EXPONENT;
   operand_type csr_wdata = 0;
   logic        idle_off = 0;   // no idling in the closing stretch
   longint      cycle_count = 0;

   mexp_req_if req_ch ();
   mexp_rsp_if rsp_ch ();

   power_scoreboard board = new();

   modular_exponentiation_unit dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // Generous limit: covers 300+ items plus stalls, several times over.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3_000_000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // accepted items sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) board.note_base(req_ch.base_value);
      if (!reset && rsp_ch.valid && rsp_ch.ready) board.check_power(rsp_ch.power_result);
   end

   // response-side stalls in bursts, changed on the falling edge
   initial begin
      int n;
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (idle_off || $urandom_range(0, 3) != 0) begin
            rsp_ch.ready = 1;
            n = $urandom_range(1, 40);
         end else begin
            rsp_ch.ready = 0;
            n = $urandom_range(1, 14);
         end
         repeat (n - 1) @(negedge clock);
      end
   end

   initial begin
      req_ch.valid = 0;
      req_ch.base_value = 0;
   end

   task automatic send_base(logic [31:0] b);
      if (!idle_off && $urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 14)) @(negedge clock);
      req_ch.valid = 1;
      req_ch.base_value = b;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 0;
   endtask

   // wait until every result is in, then let the bench idle
   task automatic drain();
      while (board.pending_powers.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic set_reg(logic [CSR_IDX_WIDTH-1:0] idx, logic [31:0] val);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 0;
      board.write_reg(idx, val);
   endtask

   function automatic logic [31:0] rand_base();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [31:0] mods[5];
      logic [31:0] exps[5];
      repeat (7) @(negedge clock);
      reset = 0;

      // directed: reset registers (modulus one) then edge cases
      send_base(32'd5);
      send_base(32'hFFFF_FFFF);
      drain();
      set_reg(CSR_MODULUS, 32'hFFFF_FFFF);
      set_reg(CSR_EXPONENT, 0);          // exponent zero gives 1
      send_base(0);
      send_base(32'hFFFF_FFFF);
      drain();
      set_reg(CSR_EXPONENT, 32'hFFFF_FFFF);
      send_base(0);
      send_base(1);
      send_base(32'hFFFF_FFFE);
      send_base(32'hFFFF_FFFF);          // base equals modulus
      send_base(32'hAAAA_5555);
      drain();
      set_reg(CSR_MODULUS, 2);
      set_reg(CSR_EXPONENT, 32'd3);
      send_base(32'd7);
      send_base(32'd8);
      drain();
      set_reg(CSR_MODULUS, 32'd65537);
      set_reg(CSR_EXPONENT, 32'h8000_0001);
      send_base(32'h5555_AAAA);
      send_base(32'd65537);
      drain();
      set_reg(CSR_MODULUS, 0);           // modulus zero also yields 0
      send_base(32'd9);
      drain();

      // random phases through several register settings
      mods = '{32'hFFFF_FFFF, 32'hFFFF_FFFB, 1, 3, 0};
      exps = '{32'hFFFF_FFFF, 0, 65537, 1, 2};
      for (int ph = 0; ph < 12; ph++) begin
         set_reg(CSR_MODULUS, (ph < 5) ? mods[ph] :
                 ($urandom_range(0, 1) ? $urandom : $urandom_range(2, 1000)));
         set_reg(CSR_EXPONENT, (ph < 5) ? exps[ph] : $urandom);
         if (ph == 10) idle_off = 1;
         repeat (24) send_base(rand_base());
         drain();
      end

      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
